// ===== design/ole_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ordered list engine.
// Depends on nothing; every module of the block imports it.
package ole_pkg;

  // Field widths of the transaction payloads
  localparam int CMD_W    = 4;
  localparam int KEY_W    = 31;
  localparam int PAY_W    = 16;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 3;

  // Default build values and the widest cell index the chain supports
  localparam int DEPTH_DEF        = 64;
  localparam int PAYLOAD_BITS_DEF = 16;
  localparam int IDX_MAX_W        = 10;

  // Configuration register
  localparam logic             REG_MAX_ENTRIES = 1'b0;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RM_FRONT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RM_BACK   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RM_AT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RM_KEY    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FIND      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ_AT   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CONTAINS  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd10;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd11;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // What every cell does at each clock edge
  typedef enum logic [1:0] {
    CM_HOLD,  // keep contents
    CM_INS,   // above sel take left neighbor, at sel load new entry
    CM_RM,    // at and above sel take right neighbor
    CM_ROT    // at sel load new entry, elsewhere take right neighbor
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t           mode;
    logic [IDX_MAX_W-1:0] sel;
  } cell_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
    logic [POS_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [PAY_W-1:0]    out_payload;
    logic [CNT_W-1:0]    match_count;
    logic [CNT_W-1:0]    entries_now;
  } out_t;

endpackage

// ===== design/ole_cell.sv =====
`timescale 1ns / 1ps
// One list position of the ordered list engine: holds a key and a payload.
// Depends on ole_pkg for the broadcast control struct.
module ole_cell #(
  parameter int PAYLOAD_BITS = ole_pkg::PAYLOAD_BITS_DEF,
  parameter int CELL_INDEX   = 0
) (
  input  logic                        clk,
  input  ole_pkg::cell_ctl_t          ctl,
  input  logic [ole_pkg::KEY_W-1:0]   new_key,
  input  logic [PAYLOAD_BITS-1:0]     new_pay,
  input  logic [ole_pkg::KEY_W-1:0]   left_key,
  input  logic [PAYLOAD_BITS-1:0]     left_pay,
  input  logic [ole_pkg::KEY_W-1:0]   right_key,
  input  logic [PAYLOAD_BITS-1:0]     right_pay,
  output logic [ole_pkg::KEY_W-1:0]   key,
  output logic [PAYLOAD_BITS-1:0]     pay
);
  import ole_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_INDEX);

  // Pick the source for this position from the broadcast command
  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_INS: begin
        if (MY_IDX > ctl.sel) begin
          key <= left_key;
          pay <= left_pay;
        end else if (MY_IDX == ctl.sel) begin
          key <= new_key;
          pay <= new_pay;
        end
      end
      CM_RM: begin
        if (MY_IDX >= ctl.sel) begin
          key <= right_key;
          pay <= right_pay;
        end
      end
      CM_ROT: begin
        if (MY_IDX == ctl.sel) begin
          key <= new_key;
          pay <= new_pay;
        end else begin
          key <= right_key;
          pay <= right_pay;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list engine top level: command sequencer, count and capacity
// registers, APB-style configuration port and the chain of ole_cell.
// Depends on ole_pkg and ole_cell.
//
// The list lives in a chain of DEPTH cells, entry i in cell i. Inserts and
// removes at the front, back or a position shift all cells at once (remove at
// the back moves none) and go through accept, then execute; clear and the
// error cases do the same. Remove by key, find, contains, count and read at
// position rotate the list once through the chain, one entry per cycle past
// the head cell, then finish. A new command is accepted while the previous
// result waits on the output register; the result of the next command waits
// until that register is free. Capacity is max_entries clamped to 1..DEPTH;
// lowering it below the count keeps entries.
module ordered_list_engine #(
  parameter int DEPTH        = ole_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = ole_pkg::PAYLOAD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ole_pkg::in_t in_item,
  input  logic         in_valid,
  output logic         in_ready,
  output ole_pkg::out_t out_item,
  output logic         out_valid,
  input  logic         out_ready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_FIN} state_t;

  state_t               state;
  logic [CMD_W-1:0]     cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [POS_W-1:0]     pos_r;
  logic [CW-1:0]        count;
  logic [CNT_W-1:0]     max_entries;
  logic [CW-1:0]        step;
  logic [CW-1:0]        scan_n;
  logic [CW-1:0]        mcount;
  logic                 found;
  logic [KEY_W-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;

  logic [CW-1:0]        cap;
  logic                 full;
  logic                 empty;
  logic                 slot_free;
  logic                 res_load;
  logic                 head_match;
  logic                 ex_scan;
  logic [STATUS_W-1:0]  ex_status;
  logic [CW-1:0]        ex_count;
  cell_ctl_t            ctl;
  logic [KEY_W-1:0]     bc_key;
  logic [PAYLOAD_BITS-1:0] bc_pay;

  logic [KEY_W-1:0]        cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign res_load  = slot_free && ((state == S_EXEC && !ex_scan) || state == S_FIN);
  assign pready    = 1'b1;
  assign prdata    = 32'(max_entries);

  // Clamp the capacity register to 1..DEPTH
  always_comb begin
    if (max_entries == '0) begin
      cap = CW'(1);
    end else if (32'(max_entries) > DEPTH) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(max_entries);
    end
  end

  assign full       = (count >= cap);
  assign empty      = (count == '0);
  assign head_match = (cell_key[0] == key_r);

  // Decode the held command: status, new count and cell moves; rotate in a scan
  always_comb begin
    ex_scan   = 1'b0;
    ex_status = ST_OK;
    ex_count  = count;
    ctl.mode  = CM_HOLD;
    ctl.sel   = '0;
    bc_key    = key_r;
    bc_pay    = pay_r;
    if (state == S_EXEC) begin
      unique case (cmd_r)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (full) begin
            ex_status = ST_FULL;
          end else begin
            ctl.mode = CM_INS;
            ctl.sel  = (cmd_r == CMD_INS_FRONT) ? '0 : IDX_MAX_W'(count);
            ex_count = count + CW'(1);
          end
        end
        CMD_INS_AT: begin
          if (full) begin
            ex_status = ST_FULL;
          end else if (32'(pos_r) >= 32'(cap)) begin
            ex_status = ST_BAD_POS;
          end else begin
            ctl.mode = CM_INS;
            ctl.sel  = (32'(pos_r) < 32'(count)) ? IDX_MAX_W'(pos_r)
                                                 : IDX_MAX_W'(count);
            ex_count = count + CW'(1);
          end
        end
        CMD_RM_FRONT, CMD_RM_BACK: begin
          if (empty) begin
            ex_status = ST_EMPTY;
          end else begin
            ctl.mode = (cmd_r == CMD_RM_FRONT) ? CM_RM : CM_HOLD;
            ex_count = count - CW'(1);
          end
        end
        CMD_RM_AT: begin
          if (empty) begin
            ex_status = ST_EMPTY;
          end else if (32'(pos_r) >= 32'(count)) begin
            ex_status = ST_BAD_POS;
          end else begin
            ctl.mode = CM_RM;
            ctl.sel  = IDX_MAX_W'(pos_r);
            ex_count = count - CW'(1);
          end
        end
        CMD_READ_AT: begin
          if (empty) begin
            ex_status = ST_EMPTY;
          end else if (32'(pos_r) >= 32'(count)) begin
            ex_status = ST_BAD_POS;
          end else begin
            ex_scan = 1'b1;
          end
        end
        CMD_RM_KEY, CMD_FIND, CMD_CONTAINS, CMD_COUNT: begin
          if (empty) begin
            ex_status = ST_EMPTY;
          end else begin
            ex_scan = 1'b1;
          end
        end
        CMD_CLEAR: begin
          ex_count = '0;
        end
        default: begin
        end
      endcase
      // Move cells only when the result can be written in this cycle
      if (!slot_free) begin
        ctl.mode = CM_HOLD;
      end
    end else if (state == S_SCAN) begin
      // Rotate: the head entry goes to the tail or is dropped
      bc_key = cell_key[0];
      bc_pay = cell_pay[0];
      if (cmd_r == CMD_RM_KEY && head_match) begin
        ctl.mode = CM_RM;
        ctl.sel  = '0;
      end else begin
        ctl.mode = CM_ROT;
        ctl.sel  = IDX_MAX_W'(count - CW'(1));
      end
    end
  end

  // Chain of list cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == DEPTH - 1) ? i : i + 1;
    ole_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_key  (bc_key),
      .new_pay  (bc_pay),
      .left_key (cell_key[LI]),
      .left_pay (cell_pay[LI]),
      .right_key(cell_key[RI]),
      .right_pay(cell_pay[RI]),
      .key      (cell_key[i]),
      .pay      (cell_pay[i])
    );
  end

  // Sequencer, count, capacity register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      max_entries <= MAX_ENTRIES_RST;
      out_valid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_MAX_ENTRIES) begin
        max_entries <= pwdata[CNT_W-1:0];
      end
      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_item.cmd;
            key_r <= in_item.entry_key;
            pay_r <= PAYLOAD_BITS'(in_item.entry_payload);
            pos_r <= in_item.position;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ex_scan) begin
            step    <= '0;
            scan_n  <= count;
            mcount  <= '0;
            found   <= 1'b0;
            res_key <= '0;
            res_pay <= '0;
            state   <= S_SCAN;
          end else if (slot_free) begin
            out_valid            <= 1'b1;
            out_item.status      <= ex_status;
            out_item.out_key     <= '0;
            out_item.out_payload <= '0;
            out_item.match_count <= '0;
            out_item.entries_now <= CNT_W'(ex_count);
            count                <= ex_count;
            state                <= S_IDLE;
          end
        end
        S_SCAN: begin
          step <= step + CW'(1);
          if (head_match) begin
            if (cmd_r == CMD_RM_KEY || cmd_r == CMD_COUNT) begin
              mcount <= mcount + CW'(1);
            end
            if (cmd_r == CMD_RM_KEY) begin
              count <= count - CW'(1);
            end
            if (!found) begin
              found <= 1'b1;
              if (cmd_r == CMD_FIND) begin
                res_key <= cell_key[0];
                res_pay <= cell_pay[0];
              end
            end
          end
          if (cmd_r == CMD_READ_AT && 32'(step) == 32'(pos_r)) begin
            res_key <= cell_key[0];
            res_pay <= cell_pay[0];
          end
          if (step == scan_n - CW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if ((cmd_r == CMD_FIND || cmd_r == CMD_CONTAINS) && !found) begin
              out_item.status <= ST_NOT_FOUND;
            end else begin
              out_item.status <= ST_OK;
            end
            out_item.out_key     <= res_key;
            out_item.out_payload <= PAY_W'(res_pay);
            out_item.match_count <= CNT_W'(mcount);
            out_item.entries_now <= CNT_W'(count);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
